[rtl/tca_pkg.sv]
// Shared types and constants for the transmit class arbiter with watermark hysteresis.
// Used by the channel interfaces, the register block, the decision logic and the core.
// No dependencies.
`default_nettype none

package tca_pkg;

   localparam int QUEUE_DEPTH = 4096;
   localparam int FILL_CAP    = QUEUE_DEPTH - 1;
   localparam int FILL_W      = 12;
   localparam int MARK_W      = 12;
   localparam int SEL_W       = 2;
   localparam int TURN_W      = 2;
   localparam int CSR_DATA_W  = 32;
   localparam int CSR_ADDR_W  = 4;

   // Telemetry is granted this many times in a row before bulk gets a turn under stress.
   localparam logic [TURN_W-1:0] STRESS_TELEMETRY_TURNS = TURN_W'(2);

   localparam logic [MARK_W-1:0] HIGH_MARK_RESET = MARK_W'(3072);
   localparam logic [MARK_W-1:0] LOW_MARK_RESET  = MARK_W'(1024);

   typedef enum logic [SEL_W-1:0] {
      SEL_NONE      = 2'd0,
      SEL_TEXT      = 2'd1,
      SEL_TELEMETRY = 2'd2,
      SEL_BULK      = 2'd3
   } sel_type;

   typedef enum logic [1:0] {
      CSR_TELEMETRY_HIGH = 2'd0,
      CSR_TELEMETRY_LOW  = 2'd1,
      CSR_BULK_HIGH      = 2'd2,
      CSR_BULK_LOW       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [MARK_W-1:0] telemetry_high;
      logic [MARK_W-1:0] telemetry_low;
      logic [MARK_W-1:0] bulk_high;
      logic [MARK_W-1:0] bulk_low;
   } marks_type;

   typedef struct packed {
      logic              text_waiting;
      logic [FILL_W-1:0] telemetry_bytes;
      logic [FILL_W-1:0] bulk_bytes;
   } item_type;

   typedef struct packed {
      logic              telemetry_flag;
      logic              bulk_flag;
      logic [TURN_W-1:0] turn;
   } state_type;

   typedef struct packed {
      sel_type selected;
      logic    telemetry_pressure;
      logic    bulk_pressure;
      logic    stressed;
   } result_type;

endpackage

`default_nettype wire

[rtl/tca_if.sv]
// Valid/ready channel interfaces for requests and results of the arbiter.
// Depends on tca_pkg for field widths.
`default_nettype none

interface tca_req_if;
   logic                      valid;
   logic                      ready;
   logic                      text_waiting;
   logic [tca_pkg::FILL_W-1:0] telemetry_bytes;
   logic [tca_pkg::FILL_W-1:0] bulk_bytes;

   modport source (output valid, input ready, output text_waiting, output telemetry_bytes,
                   output bulk_bytes);
   modport sink (input valid, output ready, input text_waiting, input telemetry_bytes,
                 input bulk_bytes);
endinterface

interface tca_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [tca_pkg::SEL_W-1:0] selected_queue;
   logic                      telemetry_pressure;
   logic                      bulk_pressure;

   modport source (output valid, input ready, output selected_queue,
                   output telemetry_pressure, output bulk_pressure);
   modport sink (input valid, output ready, input selected_queue,
                 input telemetry_pressure, input bulk_pressure);
endinterface

`default_nettype wire

[rtl/tx_class_arbiter_hysteresis_top.sv]
// Transmit class arbiter with watermark hysteresis: top level.
// A taken request waits in the request register and its result in the result register;
// the request moves on when the result register is free or draining. One request per
// cycle while the result side does not stall, with a single decision pass in between.
// Synchronous reset clears both stages, the pressure flags and the turn counter, and
// loads the thresholds with 3072 (high) and 1024 (low). Depends on tca_pkg, tca_if.
`default_nettype none

module tx_class_arbiter_hysteresis_top (
   input  wire logic                           clock,
   input  wire logic                           reset,
   tca_req_if.sink                             req_chan,
   tca_rsp_if.source                           rsp_chan,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [tca_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [tca_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [tca_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready
);

   tca_pkg::marks_type marks;

   tca_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .marks   (marks)
   );

   tca_core u_core (
      .clock    (clock),
      .reset    (reset),
      .marks    (marks),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

endmodule

`default_nettype wire

[rtl/tca_csr.sv]
// APB-style register block holding the four watermark thresholds.
// Depends on tca_pkg for the register index codes and the marks struct.
`default_nettype none

module tca_csr (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           psel,
   input  wire logic                           penable,
   input  wire logic                           pwrite,
   input  wire logic [tca_pkg::CSR_ADDR_W-1:0] paddr,
   input  wire logic [tca_pkg::CSR_DATA_W-1:0] pwdata,
   output logic      [tca_pkg::CSR_DATA_W-1:0] prdata,
   output logic                                pready,
   output tca_pkg::marks_type                  marks
);

   tca_pkg::marks_type     marks_ff, marks_in;
   tca_pkg::csr_index_type index;
   logic                   write_en;
   logic [tca_pkg::MARK_W-1:0] wdata;

   // The low address bits play no part in the decode.
   assign index    = tca_pkg::csr_index_type'(paddr[3:2]);
   assign write_en = psel & penable & pwrite;
   assign wdata    = pwdata[tca_pkg::MARK_W-1:0];
   assign pready   = 1'b1;
   assign marks    = marks_ff;

   always_comb begin
      marks_in = marks_ff;
      if (write_en) begin
         unique case (index)
            tca_pkg::CSR_TELEMETRY_HIGH: marks_in.telemetry_high = wdata;
            tca_pkg::CSR_TELEMETRY_LOW:  marks_in.telemetry_low  = wdata;
            tca_pkg::CSR_BULK_HIGH:      marks_in.bulk_high      = wdata;
            tca_pkg::CSR_BULK_LOW:       marks_in.bulk_low       = wdata;
            default:                     marks_in = marks_ff;
         endcase
      end
   end

   always_comb begin
      prdata = '0;
      unique case (index)
         tca_pkg::CSR_TELEMETRY_HIGH: prdata[tca_pkg::MARK_W-1:0] = marks_ff.telemetry_high;
         tca_pkg::CSR_TELEMETRY_LOW:  prdata[tca_pkg::MARK_W-1:0] = marks_ff.telemetry_low;
         tca_pkg::CSR_BULK_HIGH:      prdata[tca_pkg::MARK_W-1:0] = marks_ff.bulk_high;
         tca_pkg::CSR_BULK_LOW:       prdata[tca_pkg::MARK_W-1:0] = marks_ff.bulk_low;
         default:                     prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         marks_ff.telemetry_high <= tca_pkg::HIGH_MARK_RESET;
         marks_ff.telemetry_low  <= tca_pkg::LOW_MARK_RESET;
         marks_ff.bulk_high      <= tca_pkg::HIGH_MARK_RESET;
         marks_ff.bulk_low       <= tca_pkg::LOW_MARK_RESET;
      end else begin
         marks_ff <= marks_in;
      end
   end

   wr_reaches_reg: assert property (@(posedge clock) disable iff (reset)
      (write_en && index == tca_pkg::CSR_BULK_LOW) |=> (marks_ff.bulk_low == $past(wdata)))
      else $error("bulk low mark not updated by write");

   no_write_holds: assert property (@(posedge clock) disable iff (reset)
      !write_en |=> $stable(marks_ff))
      else $error("thresholds changed without a write");

   read_matches: assert property (@(posedge clock) disable iff (reset)
      (index == tca_pkg::CSR_TELEMETRY_HIGH) |->
         (prdata[tca_pkg::MARK_W-1:0] == marks_ff.telemetry_high))
      else $error("read data does not match telemetry high mark");

endmodule

`default_nettype wire

[rtl/tca_decide.sv]
// Combinational grant decision: hysteresis flag update and priority selection.
// Depends on tca_pkg for the item, state, marks and result types.
`default_nettype none

module tca_decide (
   input  wire tca_pkg::item_type   item,
   input  wire tca_pkg::state_type  state,
   input  wire tca_pkg::marks_type  marks,
   output tca_pkg::result_type      result,
   output tca_pkg::state_type       state_next
);

   function automatic logic [tca_pkg::FILL_W-1:0] clamp_fill(
      input logic [tca_pkg::FILL_W-1:0] raw);
      if (32'(raw) > 32'(tca_pkg::FILL_CAP)) begin
         clamp_fill = tca_pkg::FILL_W'(tca_pkg::FILL_CAP);
      end else begin
         clamp_fill = raw;
      end
   endfunction

   // The set test comes first, so with crossed marks a level meeting both sets the flag.
   function automatic logic hysteresis(input logic flag,
                                       input logic [tca_pkg::FILL_W-1:0] level,
                                       input logic [tca_pkg::MARK_W-1:0] high,
                                       input logic [tca_pkg::MARK_W-1:0] low);
      if (level >= high) begin
         hysteresis = 1'b1;
      end else if (level <= low) begin
         hysteresis = 1'b0;
      end else begin
         hysteresis = flag;
      end
   endfunction

   logic [tca_pkg::FILL_W-1:0] tel_level;
   logic [tca_pkg::FILL_W-1:0] blk_level;
   logic                       tel_waits;
   logic                       blk_waits;
   logic                       tel_flag;
   logic                       blk_flag;
   logic                       stressed;

   assign tel_level = clamp_fill(item.telemetry_bytes);
   assign blk_level = clamp_fill(item.bulk_bytes);
   assign tel_waits = (tel_level != '0);
   assign blk_waits = (blk_level != '0);
   assign tel_flag  = hysteresis(state.telemetry_flag, tel_level,
                                 marks.telemetry_high, marks.telemetry_low);
   assign blk_flag  = hysteresis(state.bulk_flag, blk_level,
                                 marks.bulk_high, marks.bulk_low);
   assign stressed  = !item.text_waiting && tel_waits && blk_waits && tel_flag && blk_flag;

   always_comb begin
      state_next                = state;
      state_next.telemetry_flag = tel_flag;
      state_next.bulk_flag      = blk_flag;
      result.telemetry_pressure = tel_flag;
      result.bulk_pressure      = blk_flag;
      result.stressed           = stressed;
      if (item.text_waiting) begin
         result.selected = tca_pkg::SEL_TEXT;
      end else if (!tel_waits && !blk_waits) begin
         result.selected = tca_pkg::SEL_NONE;
      end else if (stressed) begin
         if (state.turn >= tca_pkg::STRESS_TELEMETRY_TURNS) begin
            state_next.turn = '0;
            result.selected = tca_pkg::SEL_BULK;
         end else begin
            state_next.turn = state.turn + tca_pkg::TURN_W'(1);
            result.selected = tca_pkg::SEL_TELEMETRY;
         end
      end else if (tel_waits && tel_flag) begin
         result.selected = tca_pkg::SEL_TELEMETRY;
      end else if (blk_waits && blk_flag) begin
         result.selected = tca_pkg::SEL_BULK;
      end else if (tel_waits) begin
         result.selected = tca_pkg::SEL_TELEMETRY;
      end else begin
         result.selected = tca_pkg::SEL_BULK;
      end
   end

endmodule

`default_nettype wire

[rtl/tca_core.sv]
// Request register, arbitration state and result register of the arbiter.
// Depends on tca_pkg, the channel interfaces and tca_decide.
`default_nettype none

module tca_core (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire tca_pkg::marks_type marks,
   tca_req_if.sink                 req_chan,
   tca_rsp_if.source               rsp_chan
);

   logic                valid_ff, valid_in;
   tca_pkg::item_type   item_ff, item_in;
   tca_pkg::state_type  state_ff, state_in;
   logic                out_valid_ff, out_valid_in;
   tca_pkg::result_type out_ff, out_in;
   tca_pkg::result_type result;
   tca_pkg::state_type  state_next;
   logic                advance;
   logic                req_take;

   tca_decide u_decide (
      .item       (item_ff),
      .state      (state_ff),
      .marks      (marks),
      .result     (result),
      .state_next (state_next)
   );

   // The registered request moves on whenever the result register is free or draining.
   assign advance        = valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in     = req_take || (valid_ff && !advance);
      item_in      = item_ff;
      state_in     = state_ff;
      out_valid_in = advance || (out_valid_ff && !rsp_chan.ready);
      out_in       = out_ff;
      if (req_take) begin
         item_in.text_waiting    = req_chan.text_waiting;
         item_in.telemetry_bytes = req_chan.telemetry_bytes;
         item_in.bulk_bytes      = req_chan.bulk_bytes;
      end
      if (advance) begin
         state_in = state_next;
         out_in   = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
         state_ff     <= '0;
      end else begin
         valid_ff     <= valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
      end
      item_ff <= item_in;
      out_ff  <= out_in;
   end

   assign rsp_chan.valid              = out_valid_ff;
   assign rsp_chan.selected_queue     = out_ff.selected;
   assign rsp_chan.telemetry_pressure = out_ff.telemetry_pressure;
   assign rsp_chan.bulk_pressure      = out_ff.bulk_pressure;

   turn_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff.turn <= tca_pkg::STRESS_TELEMETRY_TURNS)
      else $error("stress turn counter out of range");

   text_wins: assert property (@(posedge clock) disable iff (reset)
      (advance && item_ff.text_waiting) |=> (out_ff.selected == tca_pkg::SEL_TEXT))
      else $error("waiting text queue was not granted");

   bulk_clears_turn: assert property (@(posedge clock) disable iff (reset)
      (advance && result.stressed && result.selected == tca_pkg::SEL_BULK)
         |=> (state_ff.turn == '0))
      else $error("stressed bulk grant did not clear the turn counter");

   full_stall: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && out_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("request taken while both stages are held");

   flags_reported: assert property (@(posedge clock) disable iff (reset)
      advance |=> (out_ff.telemetry_pressure == state_ff.telemetry_flag &&
                   out_ff.bulk_pressure == state_ff.bulk_flag))
      else $error("reported pressure differs from stored flags");

endmodule

`default_nettype wire
